// ===== rtl/aik_pkg.sv =====
package aik_pkg;

    // Iterations of each vectoring CORDIC (valid range 8 to 24).
    localparam int CORDIC_STAGES = 16;

    // Field and datapath widths.
    localparam int LW = 17;          // link length, unsigned Q1.16
    localparam int PW = 18;          // target coordinate, signed Q2.16
    localparam int OW = 16;          // joint angle, signed Q3.13
    localparam int CW = 35;          // CORDIC x/y datapath
    localparam int AW = 34;          // CORDIC angle, Q.30 radians

    // Step counts of the digit-recurrence units.
    localparam int DIV_STEPS = 29;   // cosine quotient, Q.28 plus one integer bit
    localparam int RHO_STEPS = 18;   // square root of x^2 + y^2
    localparam int SQ_STEPS  = 29;   // square root of 2^56 - c^2

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_UPPER = 1'b0;
    localparam logic [0:0] REG_LOWER = 1'b1;

    localparam logic [LW-1:0] LINK_RESET = 17'd13317;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Control bits that ride next to the CORDIC units.
    typedef struct packed {
        logic valid;
        logic flag;
        logic zero_link;
    } t_side;

    // One CORDIC stage.
    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
    } t_cor;

    // Elementary angles atan(2^-i) in Q.30 radians.
    function automatic logic signed [AW-1:0] atan_q30(input int i);
        case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043836;
            3:       return 34'sd133525158;
            4:       return 34'sd67021686;
            5:       return 34'sd33543515;
            6:       return 34'sd16775850;
            7:       return 34'sd8388437;
            8:       return 34'sd4194282;
            9:       return 34'sd2097149;
            10:      return 34'sd1048576;
            11:      return 34'sd524288;
            12:      return 34'sd262144;
            13:      return 34'sd131072;
            14:      return 34'sd65536;
            15:      return 34'sd32768;
            16:      return 34'sd16384;
            17:      return 34'sd8192;
            18:      return 34'sd4096;
            19:      return 34'sd2048;
            20:      return 34'sd1024;
            21:      return 34'sd512;
            22:      return 34'sd256;
            23:      return 34'sd128;
            default: return 34'sd0;
        endcase
    endfunction

    // Round a Q.30 angle to Q3.13 and saturate.
    function automatic logic signed [OW-1:0] to_q13(input logic signed [AW+1:0] a);
        logic signed [AW+1:0] t;
        logic signed [AW+1:0] r;
        t = a + 36'sd65536;
        r = t >>> 17;
        if (r > 36'sd32767) begin
            return 16'sh7fff;
        end else if (r < -36'sd32768) begin
            return 16'sh8000;
        end else begin
            return r[OW-1:0];
        end
    endfunction

endpackage

// ===== rtl/aik_cordic.sv =====
module aik_cordic import aik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_x,
    output logic signed [AW-1:0] o_angle
);

    t_cor r_st [CORDIC_STAGES+1];
    t_cor n_st [CORDIC_STAGES+1];

    always_comb begin
        // Entry stage: fold the left half plane onto the right one.
        n_st[0].zero = (i_x == '0) && (i_y == '0);
        if (i_x[CW-1]) begin
            if (!i_y[CW-1]) begin
                n_st[0].x = i_y;
                n_st[0].y = -i_x;
                n_st[0].z = HALF_PI_Q30;
            end else begin
                n_st[0].x = -i_y;
                n_st[0].y = i_x;
                n_st[0].z = -HALF_PI_Q30;
            end
        end else begin
            n_st[0].x = i_x;
            n_st[0].y = i_y;
            n_st[0].z = '0;
        end

        // One micro-rotation per stage, driving y toward zero.
        for (int k = 1; k <= CORDIC_STAGES; k++) begin
            n_st[k].zero = r_st[k-1].zero;
            if (!r_st[k-1].y[CW-1]) begin
                n_st[k].x = r_st[k-1].x + ($signed(r_st[k-1].y) >>> (k-1));
                n_st[k].y = r_st[k-1].y - ($signed(r_st[k-1].x) >>> (k-1));
                n_st[k].z = r_st[k-1].z + atan_q30(k-1);
            end else begin
                n_st[k].x = r_st[k-1].x - ($signed(r_st[k-1].y) >>> (k-1));
                n_st[k].y = r_st[k-1].y + ($signed(r_st[k-1].x) >>> (k-1));
                n_st[k].z = r_st[k-1].z - atan_q30(k-1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    // A vector of zero length has angle zero.
    assign o_angle = r_st[CORDIC_STAGES].zero ? '0 : r_st[CORDIC_STAGES].z;

endmodule

// ===== rtl/arm_inverse_kinematics.sv =====
// Three-joint arm inverse kinematics.
//
// Input channel: i_in_valid / o_in_stall carry one target point (x, y, z) in
// signed Q2.16 meters. Output channel: o_out_valid / i_out_stall carry the
// base, shoulder and elbow angles in signed Q3.13 radians and a reach flag.
// An item moves at a rising edge with valid high and stall low.
//
// The user writes the link lengths via i_cfg_we / i_cfg_index / i_cfg_data only
// while no item is in flight (unenforced); both reset to 13317 (0.2032 m).
//
// Throughput is one item per cycle while the receiver does not stall. From
// acceptance to o_out_valid an item passes the 29-step cosine divider, the
// 29-step square root of 1 - c^2 and the four CORDIC units that run side by
// side.
//
// Reset clears every valid bit and restores the link lengths. When the
// receiver stalls a waiting result, the whole pipeline holds and o_in_stall
// rises; nothing is dropped or repeated.
module arm_inverse_kinematics import aik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [PW-1:0] i_target_x,
    input  logic signed [PW-1:0] i_target_y,
    input  logic signed [PW-1:0] i_target_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [OW-1:0] o_base_angle,
    output logic signed [OW-1:0] o_shoulder_angle,
    output logic signed [OW-1:0] o_elbow_angle,
    output logic                 o_out_of_reach,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [LW-1:0]        i_cfg_data
);

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic [34:0]          x2;
        logic [34:0]          y2;
        logic [34:0]          z2;
        logic [33:0]          l22;
        logic [33:0]          l32;
        logic [33:0]          l23;
    } t_sa;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic [35:0]          rho2;
        logic signed [36:0]   num;
        logic [34:0]          den;
    } t_sb;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic                 flag;
        logic                 neg;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic [34:0]          den;
        logic [35:0]          rem;
        logic [28:0]          quo;
        logic [35:0]          rn;
        logic [19:0]          rrem;
        logic [17:0]          rroot;
    } t_div;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic                 flag;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [29:0]   c;
        logic [28:0]          cmag;
        logic [17:0]          rho;
    } t_se;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic                 flag;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [29:0]   c;
        logic [17:0]          rho;
        logic [57:0]          csq;
    } t_sf;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic                 flag;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [29:0]   c;
        logic [17:0]          rho;
        logic [57:0]          n;
        logic [30:0]          srem;
        logic [28:0]          sroot;
    } t_sq;

    typedef struct packed {
        logic                 valid;
        logic                 zero_link;
        logic                 flag;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [29:0]   c;
        logic [17:0]          rho;
        logic [28:0]          s;
        logic [45:0]          l3s;
        logic signed [47:0]   l3c;
    } t_sh;

    logic [LW-1:0] r_upper;
    logic [LW-1:0] r_lower;

    logic en;

    t_sa  r_a,  n_a;
    t_sb  r_b,  n_b;
    t_div r_c,  n_c;
    t_div r_d [DIV_STEPS];
    t_div n_d [DIV_STEPS];
    t_se  r_e,  n_e;
    t_sf  r_f,  n_f;
    t_sq  r_g,  n_g;
    t_sq  r_s [SQ_STEPS];
    t_sq  n_s [SQ_STEPS];
    t_sh  r_h,  n_h;
    t_side r_side [CORDIC_STAGES+1];

    logic                 r_out_valid;
    logic signed [OW-1:0] r_base;
    logic signed [OW-1:0] r_shoulder;
    logic signed [OW-1:0] r_elbow;
    logic                 r_reach;

    logic signed [CW-1:0] c1_y, c1_x, c3_y, c3_x, ca1_y, ca1_x, ca2_y, ca2_x;
    logic signed [AW-1:0] ang_q1, ang_q3, ang_a1, ang_a2;

    // The whole pipeline moves unless a finished result is held up.
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= LINK_RESET;
            r_lower <= LINK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UPPER: r_upper <= i_cfg_data;
                REG_LOWER: r_lower <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Stage A: squares of the coordinates and the link products.
    always_comb begin
        logic signed [35:0] px, py, pz;
        px = i_target_x * i_target_x;
        py = i_target_y * i_target_y;
        pz = i_target_z * i_target_z;
        n_a.valid     = i_in_valid;
        n_a.zero_link = (r_upper == '0) || (r_lower == '0);
        n_a.x         = i_target_x;
        n_a.y         = i_target_y;
        n_a.z         = i_target_z;
        n_a.x2        = px[34:0];
        n_a.y2        = py[34:0];
        n_a.z2        = pz[34:0];
        n_a.l22       = r_upper * r_upper;
        n_a.l32       = r_lower * r_lower;
        n_a.l23       = r_upper * r_lower;
    end

    // Stage B: planar and full squared reach, cosine numerator and denominator.
    always_comb begin
        logic [35:0] r2;
        logic [34:0] lsum;
        n_b.valid     = r_a.valid;
        n_b.zero_link = r_a.zero_link;
        n_b.x         = r_a.x;
        n_b.y         = r_a.y;
        n_b.z         = r_a.z;
        n_b.rho2      = {1'b0, r_a.x2} + {1'b0, r_a.y2};
        r2            = n_b.rho2 + {1'b0, r_a.z2};
        lsum          = {1'b0, r_a.l22} + {1'b0, r_a.l32};
        n_b.num       = $signed({1'b0, r2}) - $signed({2'b0, lsum});
        n_b.den       = {r_a.l23, 1'b0};
    end

    // Stage C: clamp the cosine; an out-of-range ratio divides den by itself.
    always_comb begin
        logic signed [36:0] sden;
        logic [36:0]        anum;
        logic               hi, lo;
        sden = $signed({2'b0, r_b.den});
        anum = r_b.num[36] ? 37'(-r_b.num) : r_b.num;
        hi   = r_b.num > sden;
        lo   = r_b.num < -sden;
        n_c.valid     = r_b.valid;
        n_c.zero_link = r_b.zero_link;
        n_c.flag      = hi || lo;
        n_c.neg       = r_b.num[36];
        n_c.x         = r_b.x;
        n_c.y         = r_b.y;
        n_c.z         = r_b.z;
        n_c.den       = r_b.den;
        n_c.rem       = (hi || lo) ? {1'b0, r_b.den} : anum[35:0];
        n_c.quo       = '0;
        n_c.rn        = r_b.rho2;
        n_c.rrem      = '0;
        n_c.rroot     = '0;
    end

    // Divider stages, one quotient bit each; the rho square root shares them.
    always_comb begin
        t_div        p;
        logic        qb;
        logic [35:0] r1;
        logic [21:0] t, trial;
        for (int k = 0; k < DIV_STEPS; k++) begin
            p  = (k == 0) ? r_c : r_d[k-1];
            qb = p.rem >= {1'b0, p.den};
            r1 = qb ? (p.rem - {1'b0, p.den}) : p.rem;
            n_d[k]     = p;
            n_d[k].quo = {p.quo[27:0], qb};
            n_d[k].rem = {r1[34:0], 1'b0};
            t     = {p.rrem, p.rn[35:34]};
            trial = {2'b0, p.rroot, 2'b01};
            if (k < RHO_STEPS) begin
                n_d[k].rn = {p.rn[33:0], 2'b00};
                if (t >= trial) begin
                    n_d[k].rrem  = 20'(t - trial);
                    n_d[k].rroot = {p.rroot[16:0], 1'b1};
                end else begin
                    n_d[k].rrem  = t[19:0];
                    n_d[k].rroot = {p.rroot[16:0], 1'b0};
                end
            end
        end
    end

    // Stage E: signed cosine in Q.28.
    always_comb begin
        t_div p;
        p = r_d[DIV_STEPS-1];
        n_e.valid     = p.valid;
        n_e.zero_link = p.zero_link;
        n_e.flag      = p.flag;
        n_e.x         = p.x;
        n_e.y         = p.y;
        n_e.z         = p.z;
        n_e.cmag      = p.quo;
        n_e.c         = p.neg ? -$signed({1'b0, p.quo}) : $signed({1'b0, p.quo});
        n_e.rho       = p.rroot;
    end

    // Stage F: c squared.
    always_comb begin
        n_f.valid     = r_e.valid;
        n_f.zero_link = r_e.zero_link;
        n_f.flag      = r_e.flag;
        n_f.x         = r_e.x;
        n_f.y         = r_e.y;
        n_f.z         = r_e.z;
        n_f.c         = r_e.c;
        n_f.rho       = r_e.rho;
        n_f.csq       = r_e.cmag * r_e.cmag;
    end

    // Stage G: radicand 2^56 - c^2 for the sine.
    always_comb begin
        n_g.valid     = r_f.valid;
        n_g.zero_link = r_f.zero_link;
        n_g.flag      = r_f.flag;
        n_g.x         = r_f.x;
        n_g.y         = r_f.y;
        n_g.z         = r_f.z;
        n_g.c         = r_f.c;
        n_g.rho       = r_f.rho;
        n_g.n         = (58'd1 << 56) - r_f.csq;
        n_g.srem      = '0;
        n_g.sroot     = '0;
    end

    // Square root stages, one root bit each.
    always_comb begin
        t_sq         p;
        logic [32:0] t, trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            p     = (k == 0) ? r_g : r_s[k-1];
            t     = {p.srem, p.n[57:56]};
            trial = {2'b0, p.sroot, 2'b01};
            n_s[k]   = p;
            n_s[k].n = {p.n[55:0], 2'b00};
            if (t >= trial) begin
                n_s[k].srem  = 31'(t - trial);
                n_s[k].sroot = {p.sroot[27:0], 1'b1};
            end else begin
                n_s[k].srem  = t[30:0];
                n_s[k].sroot = {p.sroot[27:0], 1'b0};
            end
        end
    end

    // Stage H: L3 times sine and cosine.
    always_comb begin
        t_sq p;
        p = r_s[SQ_STEPS-1];
        n_h.valid     = p.valid;
        n_h.zero_link = p.zero_link;
        n_h.flag      = p.flag;
        n_h.x         = p.x;
        n_h.y         = p.y;
        n_h.z         = p.z;
        n_h.c         = p.c;
        n_h.rho       = p.rho;
        n_h.s         = p.sroot;
        n_h.l3s       = r_lower * p.sroot;
        n_h.l3c       = $signed({1'b0, r_lower}) * $signed(p.c);
    end

    // CORDIC operands, scaled as the angle formulas need them.
    always_comb begin
        logic signed [47:0] nl3s;
        logic signed [47:0] sh_s;
        logic signed [47:0] sh_c;
        nl3s  = -$signed({2'b0, r_h.l3s});
        sh_s  = nl3s >>> 16;
        sh_c  = r_h.l3c >>> 16;
        c1_y  = $signed({{5{r_h.x[PW-1]}}, r_h.x, 12'b0});
        c1_x  = $signed({{5{r_h.y[PW-1]}}, r_h.y, 12'b0});
        c3_y  = $signed({6'b0, r_h.s});
        c3_x  = $signed({{5{r_h.c[29]}}, r_h.c});
        ca1_y = $signed({{5{r_h.z[PW-1]}}, r_h.z, 12'b0});
        ca1_x = $signed({5'b0, r_h.rho, 12'b0});
        ca2_y = sh_s[CW-1:0];
        ca2_x = $signed({6'b0, r_upper, 12'b0}) + sh_c[CW-1:0];
    end

    aik_cordic u_cor_base (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (c1_y),
        .i_x     (c1_x),
        .o_angle (ang_q1)
    );

    aik_cordic u_cor_elbow (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (c3_y),
        .i_x     (c3_x),
        .o_angle (ang_q3)
    );

    aik_cordic u_cor_reach (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (ca1_y),
        .i_x     (ca1_x),
        .o_angle (ang_a1)
    );

    aik_cordic u_cor_link (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (ca2_y),
        .i_x     (ca2_x),
        .o_angle (ang_a2)
    );

    // Pipeline registers and the control bits that follow the CORDIC units.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_f.valid <= 1'b0;
            r_g.valid <= 1'b0;
            r_h.valid <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_d[k].valid <= 1'b0;
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_s[k].valid <= 1'b0;
            end
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
            r_g <= n_g;
            r_s <= n_s;
            r_h <= n_h;
            r_side[0].valid     <= r_h.valid;
            r_side[0].flag      <= r_h.flag;
            r_side[0].zero_link <= r_h.zero_link;
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output register: joint angles, rounded to Q3.13.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_side[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [AW+1:0] q1v, q2v, q3v;
        q1v = -$signed({{2{ang_q1[AW-1]}}, ang_q1});
        q3v = -$signed({{2{ang_q3[AW-1]}}, ang_q3});
        q2v = $signed({{2{ang_a1[AW-1]}}, ang_a1}) - $signed({{2{ang_a2[AW-1]}}, ang_a2});
        if (en) begin
            if (r_side[CORDIC_STAGES].zero_link) begin
                r_base     <= '0;
                r_shoulder <= '0;
                r_elbow    <= '0;
                r_reach    <= 1'b1;
            end else begin
                r_base     <= to_q13(q1v);
                r_shoulder <= to_q13(q2v);
                r_elbow    <= to_q13(q3v);
                r_reach    <= r_side[CORDIC_STAGES].flag;
            end
        end
    end

    assign o_base_angle     = r_base;
    assign o_shoulder_angle = r_shoulder;
    assign o_elbow_angle    = r_elbow;
    assign o_out_of_reach   = r_reach;

    // No result is offered right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A held result freezes the pipeline and blocks new items.
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input accepted while a result is held");

    // With both links present, the clamped cosine magnitude never exceeds one.
    a_cos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d[DIV_STEPS-1].valid && !r_d[DIV_STEPS-1].zero_link
        |-> r_d[DIV_STEPS-1].quo <= 29'd268435456)
        else $error("cosine quotient above one");

    // With both links present, the sine from the square root stays within one.
    a_sin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h.valid && !r_h.zero_link |-> r_h.s <= 29'd268435456)
        else $error("sine above one");

endmodule
